// ===== src/sdht_pkg.sv =====
// Package with the types and constants of the shot detection and heat tracker.
package sdht_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_HEAT_PER_SHOT   = 2'd0,
        CFG_DROP_THRESHOLD  = 2'd1,
        CFG_RISE_THRESHOLD  = 2'd2,
        CFG_OVERRIDE_MARGIN = 2'd3
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] RST_HEAT_PER_SHOT   = 16'd10;
    localparam logic [15:0] RST_DROP_THRESHOLD  = 16'd220;
    localparam logic [15:0] RST_RISE_THRESHOLD  = 16'd30;
    localparam logic [15:0] RST_OVERRIDE_MARGIN = 16'd15;

    // Heat is kept in thousandths of a heat unit.
    localparam int unsigned MILLI_W = 10;
    localparam logic [MILLI_W-1:0] MILLI = 10'd1000;

    // A 16-bit value times 1000 fits in this many bits.
    localparam int unsigned MILLI_PROD_W = 16 + MILLI_W;

    localparam logic [15:0] SPEED_MAX = 16'hFFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [16:0] wheel_speed;
        logic [15:0]        cooling_rate;
        logic [15:0]        referee_heat;
        logic [15:0]        cooling_limit;
    } t_in_item;

    typedef struct packed {
        logic [31:0] heat_milli;
        logic [31:0] shots_fired;
        logic        shot_seen;
        logic        armed;
    } t_out_item;

endpackage

// ===== src/sdht_in_if.sv =====
// Valid/ready channel that carries one input item per transaction.
interface sdht_in_if;
    logic               valid;
    logic               ready;
    sdht_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/sdht_out_if.sv =====
// Valid/ready channel that carries one result item per transaction.
interface sdht_out_if;
    logic                valid;
    logic                ready;
    sdht_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/shot_detect_heat_tracker.sv =====
// Shot detector and heat tracker: each input transaction gives one result via
// the stage 1 registers and the output register. A new transaction can be
// accepted in every cycle unless stage 1 is full and the output stalls, so the
// sustained rate is one item per clock without back-pressure. The speed history
// lives in a circular memory of WINDOW entries; each accepted transaction reads
// the sample taken WINDOW items earlier and overwrites it with the new magnitude
// at the same edge, so no forwarding is needed. The heat, shot count and armed
// flag are updated in the second stage by a feedback loop; the output register
// lets a new transaction enter while a result waits to be taken.
module shot_detect_heat_tracker #(
    parameter int unsigned WINDOW = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sdht_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sdht_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    sdht_in_if.sink                              i_in,
    sdht_out_if.source                           o_out
);

    localparam int unsigned AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FILLW = $clog2(WINDOW + 1);
    localparam int unsigned LIMW  = 16 + $clog2(WINDOW + 1);
    localparam int unsigned PW    = sdht_pkg::MILLI_PROD_W;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW - 1);
    localparam logic [FILLW-1:0] FILL_FULL = FILLW'(WINDOW);

    // Configuration registers and their scaled copies.
    logic [15:0]     r_heat_per_shot;
    logic [15:0]     r_drop_threshold;
    logic [15:0]     r_rise_threshold;
    logic [15:0]     r_override_margin;
    logic [LIMW-1:0] r_fall_lim;
    logic [LIMW-1:0] r_rise_lim;
    logic [PW-1:0]   r_shot_heat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_per_shot   <= sdht_pkg::RST_HEAT_PER_SHOT;
            r_drop_threshold  <= sdht_pkg::RST_DROP_THRESHOLD;
            r_rise_threshold  <= sdht_pkg::RST_RISE_THRESHOLD;
            r_override_margin <= sdht_pkg::RST_OVERRIDE_MARGIN;
        end else if (i_cfg_we) begin
            unique case (sdht_pkg::t_cfg_idx'(i_cfg_idx))
                sdht_pkg::CFG_HEAT_PER_SHOT:   r_heat_per_shot   <= i_cfg_data;
                sdht_pkg::CFG_DROP_THRESHOLD:  r_drop_threshold  <= i_cfg_data;
                sdht_pkg::CFG_RISE_THRESHOLD:  r_rise_threshold  <= i_cfg_data;
                sdht_pkg::CFG_OVERRIDE_MARGIN: r_override_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_fall_lim  <= LIMW'(r_drop_threshold) * LIMW'(WINDOW);
        r_rise_lim  <= LIMW'(r_rise_threshold) * LIMW'(WINDOW);
        r_shot_heat <= PW'(r_heat_per_shot) * PW'(sdht_pkg::MILLI);
    end

    // Handshake control.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_stall;
    logic in_accept;
    logic s1_adv;

    assign out_stall = r_out_valid && !o_out.ready;
    assign i_in.ready = !(r_s1_valid && out_stall);
    assign in_accept = i_in.valid && i_in.ready;
    assign s1_adv = r_s1_valid && !out_stall;

    // Stage 0: magnitude, override test, history memory access.
    logic [16:0] neg_speed;
    logic [16:0] abs_speed;
    logic [15:0] mag;
    logic [16:0] override_lvl;
    logic        override_hit;

    always_comb begin
        neg_speed = 17'd0 - 17'(i_in.data.wheel_speed);
        abs_speed = i_in.data.wheel_speed[16] ? neg_speed : 17'(i_in.data.wheel_speed);
        mag = abs_speed[16] ? sdht_pkg::SPEED_MAX : abs_speed[15:0];
        override_lvl = {1'b0, i_in.data.cooling_limit} + {1'b0, r_override_margin};
        override_hit = {1'b0, i_in.data.referee_heat} >= override_lvl;
    end

    logic [15:0]      r_speed_mem [WINDOW];
    logic [15:0]      r_old_speed;
    logic [AW-1:0]    r_wr_addr;
    logic [FILLW-1:0] r_fill;

    // Read-first access: the old sample comes out as the new one goes in.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_old_speed <= r_speed_mem[r_wr_addr];
            r_speed_mem[r_wr_addr] <= mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr <= '0;
            r_fill    <= '0;
        end else if (in_accept) begin
            r_wr_addr <= (r_wr_addr == LAST_ADDR) ? '0 : r_wr_addr + AW'(1);
            if (r_fill != FILL_FULL) begin
                r_fill <= r_fill + FILLW'(1);
            end
        end
    end

    // Stage 1 registers.
    logic [15:0]    r_s1_new;
    logic [15:0]    r_s1_cool;
    logic [PW-1:0]  r_s1_ref_milli;
    logic           r_s1_override;
    logic           r_s1_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_new       <= mag;
            r_s1_cool      <= i_in.data.cooling_rate;
            r_s1_ref_milli <= PW'(i_in.data.referee_heat) * PW'(sdht_pkg::MILLI);
            r_s1_override  <= override_hit;
            r_s1_full      <= (r_fill == FILL_FULL);
        end
    end

    // Stage 1: heat step and shot detection against the running state.
    logic [31:0] r_heat;
    logic [31:0] r_shots;
    logic        r_armed;

    logic [31:0]     cooled;
    logic [31:0]     heat_mid;
    logic [32:0]     heat_sum;
    logic [LIMW:0]   new_plus_fall;
    logic [LIMW:0]   old_plus_rise;
    logic            fell;
    logic            rose;
    logic            shot;
    logic            n_armed;
    logic [31:0]     n_heat;
    logic [31:0]     n_shots;

    always_comb begin
        cooled   = (r_heat > 32'(r_s1_cool)) ? r_heat - 32'(r_s1_cool) : 32'd0;
        heat_mid = r_s1_override ? 32'(r_s1_ref_milli) : cooled;

        new_plus_fall = (LIMW + 1)'(r_s1_new) + (LIMW + 1)'(r_fall_lim);
        old_plus_rise = (LIMW + 1)'(r_old_speed) + (LIMW + 1)'(r_rise_lim);
        fell = r_s1_full && ((LIMW + 1)'(r_old_speed) > new_plus_fall);
        rose = r_s1_full && !fell && ((LIMW + 1)'(r_s1_new) > old_plus_rise);
        shot = rose && r_armed;

        n_armed = fell ? 1'b1 : (shot ? 1'b0 : r_armed);

        heat_sum = {1'b0, heat_mid} + 33'(r_shot_heat);
        if (shot) begin
            n_heat = heat_sum[32] ? sdht_pkg::COUNT_MAX : heat_sum[31:0];
        end else begin
            n_heat = heat_mid;
        end

        if (shot && (r_shots != sdht_pkg::COUNT_MAX)) begin
            n_shots = r_shots + 32'd1;
        end else begin
            n_shots = r_shots;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat  <= '0;
            r_shots <= '0;
            r_armed <= 1'b0;
        end else if (s1_adv) begin
            r_heat  <= n_heat;
            r_shots <= n_shots;
            r_armed <= n_armed;
        end
    end

    // Output register.
    sdht_pkg::t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_stall) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data.heat_milli  <= n_heat;
            r_out_data.shots_fired <= n_shots;
            r_out_data.shot_seen   <= shot;
            r_out_data.armed       <= n_armed;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ===== bench/tb_shot_detect_heat_tracker.sv =====
// Self-checking testbench for the shot detector and heat tracker.
module tb_shot_detect_heat_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW        = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 60;
    localparam int HOLD_AFTER    = 30;
    localparam int NUM_DIRECTED  = 22;
    localparam int SENDER        = 0;
    localparam int RECEIVER      = 1;

    // One row of the directed table; the result fields count only when typed is set.
    typedef struct packed {
        int          speed;
        int          cool;
        int          ref_heat;
        int          limit;
        bit          typed;
        int unsigned heat;
        int unsigned shots;
        bit          seen;
        bit          armed;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sdht_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [sdht_pkg::CFG_DATA_W-1:0] i_cfg_data;

    sdht_in_if  in_ch ();
    sdht_out_if out_ch ();

    shot_detect_heat_tracker #(.WINDOW(WINDOW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_dir_row dir_rows [NUM_DIRECTED] = '{
        //  speed   cool  ref_heat  limit typed heat   shots seen armed
        '{      0,     0,     0,     0, 1,        0, 0, 0, 0},
        '{ -65536,     0, 65535,     0, 1, 65535000, 0, 0, 0},
        '{  65535, 65535, 65535, 65535, 1, 65469465, 0, 0, 0},
        '{ -65535,     0,    15,     0, 1,    15000, 0, 0, 0},
        '{      1,  1000,    14,     0, 1,    14000, 0, 0, 0},
        '{     -1, 20000,     0, 65535, 1,        0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{  -5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{  -5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0, 65535, 65520, 0, 0, 0, 0, 0},
        '{   5000, 65535,     0,     0, 0, 0, 0, 0, 0},
        '{   5000,     0, 65535, 65521, 0, 0, 0, 0, 0},
        '{   3240,     0,     0,     0, 0, 0, 0, 0, 0},
        '{  -3239,     0,     0,     0, 0, 0, 0, 0, 0},
        '{   5240,     0,     0,     0, 0, 0, 0, 0, 0},
        '{  -5241,     0,     0,     0, 0, 0, 0, 0, 0},
        '{ -65536, 65535,     0,     0, 0, 0, 0, 0, 0}
    };

    // Tracker state as the block should hold it.
    logic [15:0] speed_line [0:WINDOW];
    int          line_fill    = 0;
    bit          rise_pending = 1'b0;
    logic [31:0] heat_est     = '0;
    logic [31:0] shot_count   = '0;
    logic [15:0] heat_per_shot = sdht_pkg::RST_HEAT_PER_SHOT;
    logic [15:0] drop_thr      = sdht_pkg::RST_DROP_THRESHOLD;
    logic [15:0] rise_thr      = sdht_pkg::RST_RISE_THRESHOLD;
    logic [15:0] margin        = sdht_pkg::RST_OVERRIDE_MARGIN;

    sdht_pkg::t_out_item due_reports [$];
    int        recent_mags [$];
    bit        aim_fall = 1'b1;
    int        gap_left [2] = '{0, 0};
    bit        gap_calm [2] = '{1'b0, 1'b0};
    int        error_count = 0;
    int        cycle_count = 0;

    function automatic logic [15:0] speed_mag(logic [16:0] raw);
        logic [16:0] mag;
        mag = raw[16] ? 17'h0 - raw : raw;
        return (mag > 17'h0FFFF) ? sdht_pkg::SPEED_MAX : mag[15:0];
    endfunction

    function automatic sdht_pkg::t_out_item track_tick(sdht_pkg::t_in_item it);
        sdht_pkg::t_out_item res;
        longint      diff;
        logic [32:0] sum;
        int          excess;
        int          i;
        if (heat_est > 32'(it.cooling_rate)) begin
            heat_est = heat_est - 32'(it.cooling_rate);
        end else begin
            heat_est = '0;
        end
        excess = int'(it.referee_heat) - int'(it.cooling_limit);
        if (excess >= int'(margin)) begin
            heat_est = 32'(it.referee_heat) * 32'd1000;
        end

        for (i = WINDOW; i > 0; i--) begin
            speed_line[i] = speed_line[i-1];
        end
        speed_line[0] = speed_mag(it.wheel_speed);
        if (line_fill < WINDOW + 1) begin
            line_fill++;
        end

        res.shot_seen = 1'b0;
        if (line_fill == WINDOW + 1) begin
            diff = longint'(speed_line[0]) - longint'(speed_line[WINDOW]);
            if (diff < -(longint'(drop_thr) * WINDOW)) begin
                rise_pending = 1'b1;
            end else if (diff > longint'(rise_thr) * WINDOW && rise_pending) begin
                sum = {1'b0, heat_est} + 33'(heat_per_shot) * 33'd1000;
                heat_est = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (shot_count != sdht_pkg::COUNT_MAX) begin
                    shot_count++;
                end
                rise_pending  = 1'b0;
                res.shot_seen = 1'b1;
            end
        end
        res.heat_milli  = heat_est;
        res.shots_fired = shot_count;
        res.armed       = rise_pending;
        return res;
    endfunction

    // Stretches of random waits mix with stretches where a side never waits.
    function automatic int draw_wait(int side);
        if (gap_left[side] == 0) begin
            gap_left[side] = $urandom_range(16, 48);
            gap_calm[side] = ($urandom_range(0, 3) == 0);
        end
        gap_left[side]--;
        return gap_calm[side] ? 0 : int'($urandom_range(0, 7));
    endfunction

    // A shaped speed lands just past the fall or rise threshold relative to the
    // sample one window back, alternating, so the detector arms and fires often.
    function automatic sdht_pkg::t_in_item pick_item(bit shaped, int cool_max);
        sdht_pkg::t_in_item it;
        int       mag;
        int       prior;
        int       lim;
        int       ref_val;
        if (shaped && recent_mags.size() == WINDOW) begin
            prior = recent_mags[0];
            if (aim_fall) begin
                mag = prior - int'(drop_thr) * WINDOW - 1 - int'($urandom_range(0, 40));
            end else begin
                mag = prior + int'(rise_thr) * WINDOW + 1 + int'($urandom_range(0, 40));
            end
            mag = (mag < 0) ? 0 : (mag > 65535) ? 65535 : mag;
            aim_fall = !aim_fall;
            it.wheel_speed = $urandom_range(0, 1) ? 17'(-mag) : 17'(mag);
        end else begin
            it.wheel_speed = 17'($urandom_range(0, 32'h1FFFF));
        end
        recent_mags.push_back(int'(speed_mag(it.wheel_speed)));
        if (recent_mags.size() > WINDOW) begin
            void'(recent_mags.pop_front());
        end

        it.cooling_rate = 16'($urandom_range(0, cool_max));
        lim = $urandom_range(0, 65535);
        case ($urandom_range(0, 3))
            0: ref_val = $urandom_range(0, 65535);
            1: ref_val = lim + int'(margin);
            2: ref_val = lim + int'(margin) - 1;
            default: begin
                ref_val = $urandom_range(0, 65535);
                lim     = 65535;
            end
        endcase
        if (ref_val > 65535) begin
            ref_val = $urandom_range(0, 65535);
        end
        if (ref_val < 0) begin
            ref_val = 0;
        end
        it.referee_heat  = 16'(ref_val);
        it.cooling_limit = 16'(lim);
        return it;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_item(sdht_pkg::t_in_item it, bit typed, sdht_pkg::t_out_item want);
        sdht_pkg::t_out_item predicted;
        int        gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = track_tick(it);
        due_reports.push_back(typed ? want : predicted);
        gap = draw_wait(SENDER);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic close_batch();
        in_ch.valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(sdht_pkg::t_cfg_idx idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            sdht_pkg::CFG_HEAT_PER_SHOT:  heat_per_shot = value;
            sdht_pkg::CFG_DROP_THRESHOLD: drop_thr      = value;
            sdht_pkg::CFG_RISE_THRESHOLD: rise_thr      = value;
            default:                      margin        = value;
        endcase
    endtask

    task automatic set_config(logic [15:0] hps, logic [15:0] drop, logic [15:0] rise,
                              logic [15:0] marg);
        write_reg(sdht_pkg::CFG_HEAT_PER_SHOT, hps);
        write_reg(sdht_pkg::CFG_DROP_THRESHOLD, drop);
        write_reg(sdht_pkg::CFG_RISE_THRESHOLD, rise);
        write_reg(sdht_pkg::CFG_OVERRIDE_MARGIN, marg);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, int shaped_of16, int cool_max);
        sdht_pkg::t_out_item unused;
        unused = '0;
        repeat (count) begin
            send_item(pick_item($urandom_range(0, 15) < shaped_of16, cool_max), 1'b0, unused);
        end
        close_batch();
    endtask

    initial begin : stimulus
        sdht_pkg::t_in_item  it;
        sdht_pkg::t_out_item want;
        int        r;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= sdht_pkg::CFG_HEAT_PER_SHOT;
        i_cfg_data  <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_DIRECTED; r++) begin
            it.wheel_speed   = 17'(dir_rows[r].speed);
            it.cooling_rate  = 16'(dir_rows[r].cool);
            it.referee_heat  = 16'(dir_rows[r].ref_heat);
            it.cooling_limit = 16'(dir_rows[r].limit);
            want.heat_milli  = dir_rows[r].heat;
            want.shots_fired = dir_rows[r].shots;
            want.shot_seen   = dir_rows[r].seen;
            want.armed       = dir_rows[r].armed;
            send_item(it, dir_rows[r].typed, want);
            // Keep the shaped generator in step with the directed speeds.
            recent_mags.push_back(int'(speed_mag(it.wheel_speed)));
            if (recent_mags.size() > WINDOW) begin
                void'(recent_mags.pop_front());
            end
        end
        close_batch();

        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3000)),
                   16'($urandom_range(0, 3000)), 16'($urandom_range(0, 200)));
        run_random(70, 12, 65535);

        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(50, 10, 65535);

        // Largest heat per shot with the thresholds at zero drives the heat
        // into saturation; the wide margin keeps the referee from resetting it.
        set_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        run_random(190, 15, 3000);

        set_config(16'($urandom_range(0, 65535)), 16'hFFFF, 16'hFFFF,
                   16'($urandom_range(0, 65535)));
        run_random(30, 12, 65535);

        set_config(16'($urandom_range(0, 100)), 16'($urandom_range(0, 500)),
                   16'($urandom_range(0, 500)), 16'($urandom_range(0, 65535)));
        run_random(60, 12, 65535);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : receiver
        int pause;
        int taken;
        taken = 0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            pause = draw_wait(RECEIVER);
            // One long hold lets the pipeline fill and push back on the sender.
            if (taken == HOLD_AFTER) begin
                pause = LONG_HOLD;
            end
            if (pause > 0) begin
                out_ch.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            taken++;
        end
    end

    always @(posedge i_clk) begin : check_results
        sdht_pkg::t_out_item want;
        sdht_pkg::t_out_item got;
        string     diffs;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.data;
            if (due_reports.size() == 0) begin
                report_mismatch("transaction on the result channel with nothing pending");
            end else begin
                want  = due_reports.pop_front();
                diffs = "";
                if (got.heat_milli !== want.heat_milli) begin
                    diffs = {diffs, $sformatf(" heat_milli %0d want %0d",
                                              got.heat_milli, want.heat_milli)};
                end
                if (got.shots_fired !== want.shots_fired) begin
                    diffs = {diffs, $sformatf(" shots_fired %0d want %0d",
                                              got.shots_fired, want.shots_fired)};
                end
                if (got.shot_seen !== want.shot_seen) begin
                    diffs = {diffs, $sformatf(" shot_seen %b want %b",
                                              got.shot_seen, want.shot_seen)};
                end
                if (got.armed !== want.armed) begin
                    diffs = {diffs, $sformatf(" armed %b want %b", got.armed, want.armed)};
                end
                if (diffs != "") begin
                    report_mismatch(diffs);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/sdht_pkg.sv
src/sdht_in_if.sv
src/sdht_out_if.sv
src/shot_detect_heat_tracker.sv
bench/tb_shot_detect_heat_tracker.sv
